### design/mcia_pkg.sv
package mcia_pkg;

  localparam int unsigned FieldW  = 16;
  localparam int unsigned CmdW    = 3;
  localparam int unsigned StatusW = 3;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 40;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned AddrW    = 8;

  localparam logic [CmdW-1:0] CmdRequest  = 3'd0;
  localparam logic [CmdW-1:0] CmdRelease  = 3'd1;
  localparam logic [CmdW-1:0] CmdResetAll = 3'd2;
  localparam logic [CmdW-1:0] CmdMark     = 3'd3;
  localparam logic [CmdW-1:0] CmdQuery    = 3'd4;

  localparam logic [StatusW-1:0] StRequested = 3'd0;
  localparam logic [StatusW-1:0] StSameOwner = 3'd1;
  localparam logic [StatusW-1:0] StNew       = 3'd2;
  localparam logic [StatusW-1:0] StNoneFree  = 3'd3;
  localparam logic [StatusW-1:0] StDone      = 3'd4;

  localparam logic [CfgIdxW-1:0] CfgDiagMask = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgDiagAddr = 1'd1;

  localparam logic [FieldW-1:0] DiagMaskRst = 16'hFF00;

  typedef struct packed {
    logic [4:0]        pad;
    logic [FieldW-1:0] owner_tag;
    logic [FieldW-1:0] client_id;
    logic [CmdW-1:0]   cmd;
  } mcia_in_t;

  typedef struct packed {
    logic [3:0]         pad;
    logic [FieldW-1:0]  holder_tag;
    logic               in_use;
    logic [StatusW-1:0] status;
    logic [FieldW-1:0]  result_id;
  } mcia_out_t;

  typedef struct packed {
    logic accept;
    logic clear;
    logic clear_cfg;
    logic lookup;
    logic step;
    logic grant_new;
    logic exec;
    logic load_out;
  } mcia_cmd_t;

  typedef struct packed {
    logic in_req;
    logic is_reset;
    logic lookup_hit;
    logic exhausted;
    logic free;
    logic clear_done;
    logic out_free;
  } mcia_status_t;

endpackage

### design/mcia_ctrl.sv
module mcia_ctrl
  import mcia_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  mcia_status_t status_i,
  output mcia_cmd_t    cmd_o
);

  typedef enum logic [6:0] {
    StateClear  = 7'b0000001,
    StateIdle   = 7'b0000010,
    StateLookup = 7'b0000100,
    StateSearch = 7'b0001000,
    StateProbe  = 7'b0010000,
    StateExec   = 7'b0100000,
    StateResp   = 7'b1000000
  } mcia_state_e;

  mcia_state_e state_q, state_d;
  logic        clr_all_q, clr_all_d;

  always_comb begin
    state_d    = state_q;
    clr_all_d  = clr_all_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StateClear: begin
        cmd_o.clear     = 1'b1;
        cmd_o.clear_cfg = clr_all_q;
        if (status_i.clear_done) begin
          clr_all_d = 1'b0;
          state_d   = clr_all_q ? StateIdle : StateResp;
        end
      end
      StateIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = status_i.in_req ? StateLookup : StateExec;
        end
      end
      StateLookup: begin
        cmd_o.lookup = 1'b1;
        state_d      = status_i.lookup_hit ? StateResp : StateSearch;
      end
      StateSearch: begin
        cmd_o.step = 1'b1;
        state_d    = status_i.exhausted ? StateResp : StateProbe;
      end
      StateProbe: begin
        if (status_i.free) begin
          cmd_o.grant_new = 1'b1;
          state_d         = StateResp;
        end else begin
          cmd_o.step = 1'b1;
          state_d    = status_i.exhausted ? StateResp : StateProbe;
        end
      end
      StateExec: begin
        cmd_o.exec = 1'b1;
        state_d    = status_i.is_reset ? StateClear : StateResp;
      end
      StateResp: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = StateIdle;
        end
      end
      default: begin
        state_d = StateIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StateClear;
      clr_all_q <= 1'b1;
    end else begin
      state_q   <= state_d;
      clr_all_q <= clr_all_d;
    end
  end

endmodule

### design/mcia_datapath.sv
module mcia_datapath
  import mcia_pkg::*;
#(
  parameter int unsigned ID_BITS  = 16,
  parameter int unsigned TAG_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [InDataW-1:0]  in_data_i,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [OutDataW-1:0] out_data_o,
  input  mcia_cmd_t           cmd_i,
  output mcia_status_t        status_o
);

  localparam int unsigned IdSpace = 2 ** ID_BITS;
  localparam int unsigned PcW     = $clog2(ID_BITS + 1);
  localparam int unsigned IdSpW   = ID_BITS + 1;

  mcia_in_t in_item;

  logic [FieldW-1:0]   diag_mask_q;
  logic [AddrW-1:0]    diag_addr_q;
  logic [ID_BITS-1:0]  next_q, next_d;
  logic [ID_BITS-1:0]  clr_q;
  logic [CmdW-1:0]     cmd_q;
  logic [ID_BITS-1:0]  cid_q;
  logic [TAG_BITS-1:0] tag_q;
  logic [ID_BITS-1:0]  tries_q;
  logic [ID_BITS-1:0]  lim_q;

  logic [ID_BITS-1:0]  res_id_q;
  logic [StatusW-1:0]  res_st_q;
  logic                res_use_q;
  logic [FieldW-1:0]   res_hold_q;

  logic                out_valid_q;
  logic [ID_BITS-1:0]  out_id_q;
  logic [StatusW-1:0]  out_st_q;
  logic                out_use_q;
  logic [FieldW-1:0]   out_hold_q;

  logic                used_mem [IdSpace];
  logic                cfg_mem  [IdSpace];
  logic [TAG_BITS-1:0] own_mem  [IdSpace];
  logic                used_rd_q;
  logic                cfg_rd_q;
  logic [TAG_BITS-1:0] own_rd_q;

  logic [ID_BITS-1:0]  fixed;
  logic [ID_BITS-1:0]  client;
  logic [ID_BITS-1:0]  smallest;
  logic [ID_BITS-1:0]  biggest;
  logic [PcW-1:0]      pc;
  logic [ID_BITS-1:0]  lim;
  logic [ID_BITS-1:0]  nxt1;
  logic [ID_BITS-1:0]  nxt2;
  logic [ID_BITS-1:0]  cand;
  logic                want_set;
  logic                hit_req;
  logic                hit_same;
  logic                exhausted;

  logic [ID_BITS-1:0]  rd_addr;
  logic [ID_BITS-1:0]  wr_addr;
  logic                used_we;
  logic                used_wd;
  logic                cfg_we;
  logic                cfg_wd;
  logic                own_we;

  assign in_item  = mcia_in_t'(in_data_i);

  assign fixed    = ID_BITS'(diag_mask_q);
  assign client   = ~fixed;
  assign smallest = ID_BITS'({diag_addr_q, 8'h00}) & fixed;
  assign biggest  = smallest | client;
  assign pc       = PcW'($countones(client));
  assign lim      = ID_BITS'((IdSpW'(1) << pc) - IdSpW'(1));

  assign nxt1 = (next_q == '1) ? smallest : next_q;
  assign nxt2 = (nxt1 == biggest) ? smallest : nxt1;
  assign cand = (next_q & fixed) | (((next_q | fixed) + ID_BITS'(1)) & client);

  assign want_set  = (cid_q != '1);
  assign hit_req   = want_set && !used_rd_q;
  assign hit_same  = want_set && used_rd_q && (own_rd_q == tag_q);
  assign exhausted = (tries_q == lim_q);

  assign status_o.in_req     = (in_item.cmd == CmdRequest);
  assign status_o.is_reset   = (cmd_q == CmdResetAll);
  assign status_o.lookup_hit = hit_req || hit_same;
  assign status_o.exhausted  = exhausted;
  assign status_o.free       = !used_rd_q && !cfg_rd_q;
  assign status_o.clear_done = (clr_q == '1);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    priority if (cmd_i.accept) begin
      rd_addr = ID_BITS'(in_item.client_id);
    end else if (cmd_i.step) begin
      rd_addr = cand;
    end else begin
      rd_addr = next_q;
    end
  end

  always_comb begin
    priority if (cmd_i.clear) begin
      wr_addr = clr_q;
    end else if (cmd_i.grant_new) begin
      wr_addr = next_q;
    end else begin
      wr_addr = cid_q;
    end
  end

  assign used_we = cmd_i.clear || (cmd_i.lookup && hit_req) || cmd_i.grant_new ||
                   (cmd_i.exec && (cmd_q == CmdRelease));
  assign used_wd = !(cmd_i.clear || cmd_i.exec);
  assign cfg_we  = (cmd_i.clear && cmd_i.clear_cfg) || (cmd_i.exec && (cmd_q == CmdMark));
  assign cfg_wd  = cmd_i.exec;
  assign own_we  = (cmd_i.lookup && hit_req) || cmd_i.grant_new;

  always_ff @(posedge clk_i) begin
    if (used_we) begin
      used_mem[wr_addr] <= used_wd;
    end
    used_rd_q <= used_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cfg_we) begin
      cfg_mem[wr_addr] <= cfg_wd;
    end
    cfg_rd_q <= cfg_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (own_we) begin
      own_mem[wr_addr] <= tag_q;
    end
    own_rd_q <= own_mem[rd_addr];
  end

  always_comb begin
    next_d = next_q;
    if (cmd_i.lookup) begin
      next_d = (hit_req || hit_same) ? nxt1 : nxt2;
    end
    if (cmd_i.step) begin
      next_d = cand;
    end
    if (cmd_i.exec && (cmd_q == CmdResetAll)) begin
      next_d = '1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diag_mask_q <= DiagMaskRst;
      diag_addr_q <= '0;
      next_q      <= '1;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CfgDiagMask: diag_mask_q <= cfg_data_i;
          CfgDiagAddr: diag_addr_q <= cfg_data_i[AddrW-1:0];
          default:     diag_mask_q <= diag_mask_q;
        endcase
      end
      next_q <= next_d;
      if (cmd_i.clear) begin
        clr_q <= clr_q + ID_BITS'(1);
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q <= in_item.cmd;
      cid_q <= ID_BITS'(in_item.client_id);
      tag_q <= TAG_BITS'(in_item.owner_tag);
    end
    if (cmd_i.lookup) begin
      tries_q <= '0;
      lim_q   <= lim;
    end else if (cmd_i.step && !exhausted) begin
      tries_q <= tries_q + ID_BITS'(1);
    end

    if (cmd_i.lookup) begin
      res_id_q   <= cid_q;
      res_st_q   <= hit_req ? StRequested : StSameOwner;
      res_use_q  <= 1'b0;
      res_hold_q <= '0;
    end else if (cmd_i.step && exhausted) begin
      res_id_q   <= '1;
      res_st_q   <= StNoneFree;
      res_use_q  <= 1'b0;
      res_hold_q <= '0;
    end else if (cmd_i.grant_new) begin
      res_id_q   <= next_q;
      res_st_q   <= StNew;
      res_use_q  <= 1'b0;
      res_hold_q <= '0;
    end else if (cmd_i.exec) begin
      res_id_q   <= '0;
      res_st_q   <= StDone;
      res_use_q  <= (cmd_q == CmdQuery) && used_rd_q;
      res_hold_q <= ((cmd_q == CmdQuery) && used_rd_q) ? FieldW'(own_rd_q) : '0;
    end

    if (cmd_i.load_out) begin
      out_id_q   <= res_id_q;
      out_st_q   <= res_st_q;
      out_use_q  <= res_use_q;
      out_hold_q <= res_hold_q;
    end
  end

  assign out_valid_o = out_valid_q;
  always_comb begin
    mcia_out_t o;
    o            = '0;
    o.result_id  = FieldW'(out_id_q);
    o.status     = out_st_q;
    o.in_use     = out_use_q;
    o.holder_tag = out_hold_q;
    out_data_o   = o;
  end

endmodule

### design/masked_client_id_allocator.sv
// Hands out client IDs of ID_BITS bits one command at a time: the bits set in
// the diagnosis mask come from the diagnosis address, the rest are searched
// next-fit from a pointer, skipping used and configured IDs. After reset the
// block sweeps its used and configured flags clear, one ID per cycle, over all
// 2^ID_BITS IDs (65536 at the default) before it takes the first item; a
// reset-all command sweeps the used flags in the same way. Release, mark and
// query pass from acceptance through the execute state to the response state;
// a request goes through the lookup state and, if it does not get the ID it
// names, searches, probing one candidate per cycle because the flag memories
// have one read port. A finished result waits in the output register while
// the next item is taken.
module masked_client_id_allocator
  import mcia_pkg::*;
#(
  parameter int unsigned ID_BITS  = 16,
  parameter int unsigned TAG_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // cmd[2:0], client_id[18:3], owner_tag[34:19], zeros above.
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // result_id[15:0], status[18:16], in_use[19], holder_tag[35:20], zeros above.
  output logic [OutDataW-1:0] m_axis_tdata_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  mcia_cmd_t    cmd;
  mcia_status_t status;

  assign cfg_ready_o = 1'b1;

  mcia_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mcia_datapath #(
    .ID_BITS  (ID_BITS),
    .TAG_BITS (TAG_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (m_axis_tdata_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule
